/* src/cbcs_pkg.sv */
// ----------------------------------------------------------------------------
// cbcs_pkg
// Types and constants shared by the cartridge-bus command serializer modules.
// ----------------------------------------------------------------------------
package cbcs_pkg;

	localparam int unsigned ItemBits = 65;
	localparam int unsigned LenW     = 7;
	localparam int unsigned AccBits  = 72;
	localparam int unsigned QDepth   = 2;

	typedef enum logic [2:0] {
		OP_ROM_WRITE_ADDR = 3'd0,
		OP_ROM_WRITE_SEQ  = 3'd1,
		OP_RAM_WRITE      = 3'd2,
		OP_RAM_READ       = 3'd3,
		OP_ROM_READ       = 3'd4,
		OP_ROM_READ_30    = 3'd5,
		OP_UNUSED_6       = 3'd6,
		OP_UNUSED_7       = 3'd7
	} opcode_t;

	localparam logic [4:0] CMD_BUS_WRITE  = 5'b00001;
	localparam logic [4:0] CMD_WR_RD      = 5'b00101;
	localparam logic [4:0] CMD_CS_WRITE   = 5'b00111;
	localparam logic [4:0] CMD_DATA_FLIP  = 5'b01100;
	localparam logic [4:0] CMD_DATA_PLAIN = 5'b01001;
	localparam logic [4:0] CMD_ROM_READ   = 5'b01011;
	localparam logic [4:0] CMD_ADDR_READ  = 5'b01000;
	localparam logic [4:0] CMD_READ_30    = 5'b00010;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [24:0] address;
		logic [15:0] data_word;
		logic        last_in_batch;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// one classified transaction: stream bits left aligned, bit count, batch end
	typedef struct packed {
		logic [ItemBits-1:0] bits;
		logic [LenW-1:0]     len;
		logic                last;
	} entry_t;

endpackage

/* src/cbcs_front.sv */
// ----------------------------------------------------------------------------
// cbcs_front
// Accepts transactions and expands each into its command bit string.
// ----------------------------------------------------------------------------
module cbcs_front
	import cbcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output entry_t   q_entry
);

	logic        halfword_q;
	logic        started_q;
	logic [23:0] rom_addr;
	logic [63:0] body;
	logic [LenW-1:0] body_len;
	logic        known;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;

	assign rom_addr = halfword_q ? in_data.address[23:0] : in_data.address[24:1];

	always_comb begin
		body     = '0;
		body_len = '0;
		known    = 1'b1;
		unique case (opcode_t'(in_data.opcode))
			OP_ROM_WRITE_ADDR: begin
				body = {CMD_BUS_WRITE, 1'b0, 1'b1, rom_addr, 4'b1110, 1'b0,
					CMD_CS_WRITE, 1'b0, 1'b0, CMD_DATA_FLIP, in_data.data_word};
				body_len = LenW'(64);
			end
			OP_ROM_WRITE_SEQ: begin
				body = {CMD_WR_RD, 2'b11, 1'b0, CMD_DATA_FLIP, in_data.data_word, 35'd0};
				body_len = LenW'(29);
			end
			OP_RAM_WRITE: begin
				body = {CMD_BUS_WRITE, 2'b00, in_data.data_word[7:0],
					in_data.address[15:0], 4'b1110, 1'b0, CMD_WR_RD, 2'b01, 21'd0};
				body_len = LenW'(43);
			end
			OP_RAM_READ: begin
				body = {CMD_DATA_PLAIN, in_data.address[15:0], 1'b0, CMD_ADDR_READ,
					8'd0, 29'd0};
				body_len = LenW'(35);
			end
			OP_ROM_READ: begin
				body = {CMD_WR_RD, 2'b10, 1'b0, CMD_ROM_READ, 16'd0, 35'd0};
				body_len = LenW'(29);
			end
			OP_ROM_READ_30: begin
				body = {CMD_WR_RD, 2'b10, 1'b0, CMD_READ_30, 30'd0, 1'b0,
					CMD_WR_RD, 2'b11, 13'd0};
				body_len = LenW'(51);
			end
			OP_UNUSED_6, OP_UNUSED_7: begin
				known = 1'b0;
			end
		endcase
	end

	always_comb begin
		q_entry.last = in_data.last_in_batch;
		if (known && started_q) begin
			q_entry.bits = {1'b0, body};
			q_entry.len  = body_len + LenW'(1);
		end else begin
			q_entry.bits = {body, 1'b0};
			q_entry.len  = body_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halfword_q <= 1'b0;
			started_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				halfword_q <= cfg_data;
			end
			if (q_push) begin
				if (in_data.last_in_batch) begin
					started_q <= 1'b0;
				end else if (known) begin
					started_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* src/cbcs_queue.sv */
// ----------------------------------------------------------------------------
// cbcs_queue
// Two-entry queue between the classifying front and the byte packer.
// ----------------------------------------------------------------------------
module cbcs_queue
	import cbcs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	entry_t     slots [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(QDepth));
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* src/cbcs_back.sv */
// ----------------------------------------------------------------------------
// cbcs_back
// Packs queued command bits behind the pending bits and sends them as bytes.
// ----------------------------------------------------------------------------
module cbcs_back
	import cbcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  entry_t    head_entry,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [AccBits-1:0] acc_q;
	logic [LenW-1:0]    cnt_q;
	logic               flush_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	logic               slot_free;
	logic               full_byte;
	logic               close_byte;
	logic               send_byte;
	logic [AccBits-1:0] loaded;

	assign slot_free  = !out_valid_q || out_ready;
	assign full_byte  = (cnt_q >= LenW'(8));
	assign close_byte = flush_q && !full_byte;
	assign send_byte  = slot_free && (full_byte || close_byte);
	assign pop        = head_valid && !full_byte && !flush_q;

	assign loaded = {acc_q[AccBits-1 -: 8], {(AccBits-8){1'b0}}}
		| ({head_entry.bits, {(AccBits-ItemBits){1'b0}}} >> cnt_q[2:0]);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (send_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				acc_q   <= loaded;
				cnt_q   <= cnt_q + head_entry.len;
				flush_q <= head_entry.last;
			end else if (slot_free && full_byte) begin
				out_data_q.out_byte  <= acc_q[AccBits-1 -: 8];
				out_data_q.last_byte <= 1'b0;
				acc_q                <= acc_q << 8;
				cnt_q                <= cnt_q - LenW'(8);
			end else if (slot_free && close_byte) begin
				out_data_q.out_byte  <= acc_q[AccBits-1 -: 8];
				out_data_q.last_byte <= 1'b1;
				acc_q                <= '0;
				cnt_q                <= '0;
				flush_q              <= 1'b0;
			end
		end
	end

endmodule

/* src/cart_bus_command_serializer.sv */
// ----------------------------------------------------------------------------
// cart_bus_command_serializer
// Turns cartridge-bus transactions into a packed, byte-wide command stream.
// ----------------------------------------------------------------------------
// Each accepted transaction is expanded combinationally into its command bits
// and placed in a two-entry queue; the packer then drains it at up to one
// output byte per cycle, holding while a byte waits on the receiver. A
// transaction is first loaded into the packer, then each full byte it
// completes (3 to 9) is sent, and a batch end adds the padded or zero closing
// byte; sustained throughput is set by the single byte-wide output register.
// A transaction with an unused opcode is only loaded and adds no bytes, but
// the closing byte when it ends a batch. The input stays ready while the queue
// has room, also while a byte waits on the output.
// ----------------------------------------------------------------------------
module cart_bus_command_serializer
	import cbcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic   q_full;
	logic   q_push;
	entry_t q_entry;
	logic   q_pop;
	logic   head_valid;
	entry_t head_entry;

	cbcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	cbcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	cbcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

/* verif/cart_bus_command_serializer_tb.sv */
// ----------------------------------------------------------------------------
// cart_bus_command_serializer_tb
// Self-checking testbench for the cartridge-bus command serializer. A class
// keeps a bit-level model of the command stream and queues the bytes that each
// accepted transaction must produce. The checker compares every output byte
// and its batch-end flag against that queue. Directed transactions cover field
// extremes, every opcode, ignored opcodes, empty batches and batches that end
// on a byte boundary. Random batches follow in three phases of sender and
// receiver idling, with a long receiver hold-off and a sender pause until the
// stream drains. Both address settings are used.
// ----------------------------------------------------------------------------
module cart_bus_command_serializer_tb;
	import cbcs_pkg::*;

	localparam int SettleCycles = 24;
	localparam int WatchdogLimit = 3000;
	localparam int HoldCycles = 400;

	class byte_stream_scoreboard;
		out_item_t expected_bytes[$];
		logic [7:0] acc_bits;
		int unsigned acc_count;
		bit batch_open;
		bit halfword_mode;
		int mismatch_count;

		function new();
			acc_bits = '0;
			acc_count = 0;
			batch_open = 0;
			halfword_mode = 0;
			mismatch_count = 0;
		endfunction

		function void set_halfword(logic v);
			halfword_mode = v;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(logic [7:0] b, logic l);
			out_item_t e;
			e.out_byte = b;
			e.last_byte = l;
			expected_bytes.insert(expected_bytes.size(), e);
		endfunction

		function void push_bits(logic [63:0] v, int n);
			for (int i = n; i > 0; i--) begin
				acc_bits = {acc_bits[6:0], v[i-1]};
				acc_count++;
				if (acc_count == 8) begin
					push_byte(acc_bits, 1'b0);
					acc_bits = '0;
					acc_count = 0;
				end
			end
		endfunction

		function void bus_write(logic cs2, logic [7:0] v8, logic [15:0] v16);
			push_bits(CMD_BUS_WRITE, 5);
			push_bits(0, 1);
			push_bits(cs2, 1);
			push_bits(v8, 8);
			push_bits(v16, 16);
			// cs1, rd, wr high, phi low
			push_bits(4'b1110, 4);
		endfunction

		function void wr_rd(logic wr, logic rd);
			push_bits(CMD_WR_RD, 5);
			push_bits({wr, rd}, 2);
		endfunction

		function void note_transaction(in_item_t it);
			logic [23:0] rom_addr;
			if (it.opcode <= OP_ROM_READ_30) begin
				if (batch_open)
					push_bits(0, 1);
				batch_open = 1;
				case (opcode_t'(it.opcode))
					OP_ROM_WRITE_ADDR: begin
						rom_addr = halfword_mode ? it.address[23:0] : it.address[24:1];
						bus_write(1'b1, rom_addr[23:16], rom_addr[15:0]);
						push_bits(0, 1);
						push_bits(CMD_CS_WRITE, 5);
						push_bits(0, 1);
						push_bits(0, 1);
						push_bits(CMD_DATA_FLIP, 5);
						push_bits(it.data_word, 16);
					end
					OP_ROM_WRITE_SEQ: begin
						wr_rd(1'b1, 1'b1);
						push_bits(0, 1);
						push_bits(CMD_DATA_FLIP, 5);
						push_bits(it.data_word, 16);
					end
					OP_RAM_WRITE: begin
						bus_write(1'b0, it.data_word[7:0], it.address[15:0]);
						push_bits(0, 1);
						wr_rd(1'b0, 1'b1);
					end
					OP_RAM_READ: begin
						push_bits(CMD_DATA_PLAIN, 5);
						push_bits(it.address[15:0], 16);
						push_bits(0, 1);
						push_bits(CMD_ADDR_READ, 5);
						push_bits(0, 8);
					end
					OP_ROM_READ: begin
						wr_rd(1'b1, 1'b0);
						push_bits(0, 1);
						push_bits(CMD_ROM_READ, 5);
						push_bits(0, 16);
					end
					default: begin
						wr_rd(1'b1, 1'b0);
						push_bits(0, 1);
						push_bits(CMD_READ_30, 5);
						push_bits(0, 30);
						push_bits(0, 1);
						wr_rd(1'b1, 1'b1);
					end
				endcase
			end
			if (it.last_in_batch) begin
				if (acc_count > 0)
					push_byte(acc_bits << (8 - acc_count), 1'b1);
				else
					push_byte(8'h00, 1'b1);
				acc_bits = '0;
				acc_count = 0;
				batch_open = 0;
			end
		endfunction

		function void check_byte(out_item_t got);
			out_item_t want;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none actual %02h last %0b",
					$time, got.out_byte, got.last_byte);
				mismatch_count++;
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h actual %02h",
					$time, want.out_byte, got.out_byte);
				mismatch_count++;
			end
			if (got.last_byte !== want.last_byte) begin
				$display("%0t: last_byte expected %0b actual %0b",
					$time, want.last_byte, got.last_byte);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	byte_stream_scoreboard sb;
	int send_idle;
	int recv_idle;
	bit hold_start;
	int stall_cycles;

	cart_bus_command_serializer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic in_item_t make_item(logic [2:0] op, logic [24:0] addr,
		logic [15:0] data, logic last);
		in_item_t it;
		it.opcode = op;
		it.address = addr;
		it.data_word = data;
		it.last_in_batch = last;
		return it;
	endfunction

	function automatic in_item_t random_item(logic [2:0] op, logic last);
		logic [24:0] addr;
		logic [15:0] data;
		addr = ($urandom_range(99) < 85) ? 25'($urandom) : {25{1'($urandom_range(1))}};
		data = ($urandom_range(99) < 85) ? 16'($urandom) : {16{1'($urandom_range(1))}};
		return make_item(op, addr, data, last);
	endfunction

	function automatic logic [2:0] pick_op();
		if ($urandom_range(99) < 92)
			return 3'($urandom_range(OP_ROM_READ_30));
		return 3'($urandom_range(OP_UNUSED_7, OP_UNUSED_6));
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_transaction(it);
	endtask

	task automatic stop_send();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_halfword(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int target, int hold_at, int pause_at);
		int sent;
		int blen;
		bit held;
		bit paused;
		in_item_t it;
		sent = 0;
		held = 0;
		paused = 0;
		while (sent < target) begin
			if ($urandom_range(99) < 15) begin
				// lone noise transaction, any opcode, any batch flag
				it = random_item(3'($urandom_range(OP_UNUSED_7)), 1'($urandom_range(1)));
				send_item(it);
				if (it.opcode <= OP_ROM_READ_30 || it.last_in_batch)
					sent++;
			end else begin
				blen = $urandom_range(6, 1);
				for (int k = 0; k < blen; k++) begin
					it = random_item(pick_op(), k == blen - 1);
					send_item(it);
					if (it.opcode <= OP_ROM_READ_30 || it.last_in_batch)
						sent++;
				end
			end
			if (!held && sent >= hold_at) begin
				hold_start = 1;
				held = 1;
			end
			if (!paused && sent >= pause_at) begin
				stop_send();
				wait_drained();
				paused = 1;
			end
		end
	endtask

	// receiver
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_left = HoldCycles;
				hold_start = 0;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_byte(out_data);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles + 1 >= WatchdogLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		hold_start = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_cfg(1'b0);
		// empty batch, then a batch ending on a byte boundary
		send_item(make_item(OP_UNUSED_6, 25'h1FFFFFF, 16'hFFFF, 1'b1));
		send_item(make_item(OP_ROM_WRITE_ADDR, 25'h1FFFFFF, 16'hFFFF, 1'b1));
		send_item(make_item(OP_ROM_WRITE_ADDR, 25'h0, 16'h0, 1'b0));
		send_item(make_item(OP_ROM_WRITE_SEQ, 25'h0, 16'hFFFF, 1'b0));
		send_item(make_item(OP_ROM_WRITE_SEQ, 25'h1FFFFFF, 16'h0, 1'b0));
		send_item(make_item(OP_RAM_WRITE, 25'h1FFFFFF, 16'hFFFF, 1'b0));
		send_item(make_item(OP_RAM_READ, 25'h1FFFFFF, 16'h0, 1'b0));
		send_item(make_item(OP_UNUSED_7, 25'h0, 16'h0, 1'b0));
		send_item(make_item(OP_ROM_READ, 25'h0, 16'hFFFF, 1'b0));
		send_item(make_item(OP_ROM_READ_30, 25'h1FFFFFF, 16'hFFFF, 1'b1));
		send_item(make_item(OP_RAM_READ, 25'h0, 16'hFFFF, 1'b1));
		send_item(make_item(OP_UNUSED_7, 25'h1FFFFFF, 16'hFFFF, 1'b1));
		stop_send();

		write_cfg(1'b1);
		send_item(make_item(OP_ROM_WRITE_ADDR, 25'h1FFFFFF, 16'h8001, 1'b1));
		send_item(make_item(OP_ROM_WRITE_ADDR, 25'h0AAAAAA, 16'h5555, 1'b0));
		send_item(make_item(OP_ROM_WRITE_ADDR, 25'h1555555, 16'hAAAA, 1'b1));
		send_item(make_item(OP_RAM_WRITE, 25'h0, 16'h0, 1'b1));
		send_item(make_item(OP_ROM_READ_30, 25'h0, 16'h0, 1'b0));
		send_item(make_item(OP_ROM_READ_30, 25'h0, 16'h0, 1'b1));
		send_item(make_item(OP_UNUSED_6, 25'h0, 16'h0, 1'b0));
		send_item(make_item(OP_ROM_READ, 25'h1FFFFFF, 16'h0, 1'b1));
		stop_send();

		send_idle = 9;
		recv_idle = 66;
		write_cfg(1'b1);
		run_random(135, 40, 1000);
		stop_send();

		send_idle = 66;
		recv_idle = 9;
		write_cfg(1'b0);
		run_random(135, 1000, 60);
		stop_send();

		send_idle = 0;
		recv_idle = 0;
		write_cfg(1'($urandom_range(1)));
		run_random(120, 1000, 1000);
		stop_send();

		settle();
		if (sb.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
src/cbcs_pkg.sv
src/cbcs_front.sv
src/cbcs_queue.sv
src/cbcs_back.sv
src/cart_bus_command_serializer.sv
verif/cart_bus_command_serializer_tb.sv
